// ===== hdl/slrc_pkg.sv =====
package slrc_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int MODE_W = 2;

    // Default store depth
    localparam int LIST_DEPTH_DEFAULT = 1024;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_C = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STREAM = 2'd2;

    // Control from the sequencer to one list unit
    typedef struct packed {
        logic load;
        logic walk;
        logic clear;
    } list_ctrl_t;

    // Status from one list unit back to the sequencer
    typedef struct packed {
        logic step;
        logic match;
    } list_stat_t;

endpackage

// ===== hdl/slrc_ram.sv =====
module slrc_ram #(
    parameter int WIDTH = slrc_pkg::DATA_W,
    parameter int DEPTH = slrc_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/slrc_list.sv =====
module slrc_list #(
    parameter int LIST_DEPTH = slrc_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  slrc_pkg::list_ctrl_t            ctrl,
    input  logic [slrc_pkg::DATA_W-1:0]     load_value,
    input  logic [slrc_pkg::DATA_W-1:0]     key,
    output slrc_pkg::list_stat_t            stat
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               cursor_reg;
    logic [CW-1:0]               cursor_next;
    logic [slrc_pkg::DATA_W-1:0] rd_data;
    logic                        write_en;
    logic                        active;
    logic                        less;

    // Append while there is room
    assign write_en = ctrl.load && (count_reg < FULL);

    // Entry under the cursor is valid only below the fill count
    assign active = cursor_reg < count_reg;
    assign less   = active && ($signed(rd_data) < $signed(key));

    assign stat.step  = ctrl.walk && less;
    assign stat.match = active && (rd_data == key);

    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        if (ctrl.clear)
        begin
            count_next  = '0;
            cursor_next = '0;
        end
        else
        begin
            if (write_en)
            begin
                count_next = count_reg + 1'b1;
            end
            if (stat.step)
            begin
                cursor_next = cursor_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
        end
    end

    // Read ahead at the next cursor so the registered data lines up with the cursor register
    slrc_ram #(
        .WIDTH (slrc_pkg::DATA_W),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (write_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (load_value),
        .raddr (cursor_next[AW-1:0]),
        .rdata (rd_data)
    );

endmodule

// ===== hdl/sorted_list_remove_common.sv =====
// Removes from sorted list A every value that is present in both sorted lists B and C.
// Items with mode 0 or 1 append a value to the B or C store (values past LIST_DEPTH are
// dropped); a mode 2 item streams one A value and yields one result with keep = 0 when
// the value is in both B and C. The A item marked last ends the problem: its result
// carries end_of_list, and the fill counts and walk cursors return to zero. Loads and
// mode 3 items are taken while idle. An A value stays in the walk state until neither
// cursor advances; B and C walk in parallel, one entry per cycle, behind the registered
// read of each store. A result waiting on out_ready holds the block in the walk state
// until it is taken.
module sorted_list_remove_common #(
    parameter int LIST_DEPTH = slrc_pkg::LIST_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [slrc_pkg::MODE_W-1:0]         mode,
    input  logic signed [slrc_pkg::DATA_W-1:0]  value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [slrc_pkg::DATA_W-1:0]  out_value,
    output logic                                keep,
    output logic                                end_of_list
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [slrc_pkg::DATA_W-1:0] key_reg;
    logic                        last_reg;
    logic                        accept;
    logic                        finish;
    logic                        out_busy;
    logic                        out_valid_reg;
    logic [slrc_pkg::DATA_W-1:0] out_value_reg;
    logic                        keep_reg;
    logic                        eol_reg;
    slrc_pkg::list_ctrl_t        b_ctrl;
    slrc_pkg::list_ctrl_t        c_ctrl;
    slrc_pkg::list_stat_t        b_stat;
    slrc_pkg::list_stat_t        c_stat;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;

    // Walk ends when neither cursor moves and the output register is free
    assign finish = (state_reg == ST_WALK) && !b_stat.step && !c_stat.step && !out_busy;

    // List unit control
    assign b_ctrl.load  = accept && (mode == slrc_pkg::MODE_LOAD_B);
    assign b_ctrl.walk  = (state_reg == ST_WALK);
    assign b_ctrl.clear = finish && last_reg;
    assign c_ctrl.load  = accept && (mode == slrc_pkg::MODE_LOAD_C);
    assign c_ctrl.walk  = (state_reg == ST_WALK);
    assign c_ctrl.clear = finish && last_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == slrc_pkg::MODE_STREAM))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= value;
            last_reg <= last;
        end
        if (finish)
        begin
            out_value_reg <= key_reg;
            keep_reg      <= !(b_stat.match && c_stat.match);
            eol_reg       <= last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign keep        = keep_reg;
    assign end_of_list = eol_reg;

    slrc_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list_b (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (b_ctrl),
        .load_value (value),
        .key        (key_reg),
        .stat       (b_stat)
    );

    slrc_list #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_list_c (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (c_ctrl),
        .load_value (value),
        .key        (key_reg),
        .stat       (c_stat)
    );

`ifndef ASSERT_OFF
    // A streamed A value always starts a walk
    a_stream_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == slrc_pkg::MODE_STREAM)) |=> (state_reg == ST_WALK))
        else $error("A transfer did not start a walk");

    // A result only appears at the end of a walk
    a_result_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_WALK))
        else $error("result raised outside a walk");

    // A held result keeps the sequencer in the walk
    a_hold_walk: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && out_valid && !out_ready) |=> (state_reg == ST_WALK))
        else $error("walk left while result was stalled");
`endif

endmodule
